// ----- design/srls_pkg.sv -----
// Shared types and constants of the scalar RLS estimator.
`timescale 1ns / 1ps

package srls_pkg;

  // Operation codes of the shared serial arithmetic unit
  typedef enum logic {
    ALU_MUL,
    ALU_DIV
  } alu_op_t;

  // Request from the sequencer to the arithmetic unit
  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_INIT_EST,
    CFG_INIT_COV,
    CFG_PRED_SCALE,
    CFG_SPARE
  } cfg_reg_t;

  localparam int unsigned FRAC_BITS = 24;

  localparam logic signed [31:0] Q_ONE   = 32'sh0100_0000;
  localparam logic signed [31:0] SAT_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

  localparam logic signed [31:0] RESET_EST   = 32'sd167772;
  localparam logic [30:0]        RESET_COV   = 31'd26844;
  localparam logic [24:0]        RESET_SCALE = 25'd16609444;

  // Saturate a 33-bit two's complement sum to 32 bits
  function automatic logic signed [31:0] sat_s33(input logic [32:0] v);
    logic signed [31:0] r;
    if (v[32] != v[31]) begin
      r = v[32] ? SAT_MIN : SAT_MAX;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ----- design/srls_serial_alu.sv -----
// Shared digit-serial multiplier (radix 16) and bit-serial divider, Q8.24.
`timescale 1ns / 1ps

module srls_serial_alu (
  input  logic                      clk,
  input  logic                      rst,
  input  srls_pkg::alu_req_t        req,
  input  logic signed [31:0]        a,
  input  logic signed [31:0]        b,
  output logic                      done,
  output logic signed [31:0]        result
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_FIN
  } state_t;

  localparam logic [5:0] MUL_LAST = 6'd7;   // eight 4-bit digits
  localparam logic [5:0] DIV_LAST = 6'd55;  // 56 quotient bits

  state_t            state;
  srls_pkg::alu_op_t op;
  logic              neg;
  logic [5:0]        cnt;
  logic [31:0]       mag;   // multiplicand or divisor magnitude
  logic [63:0]       acc;   // product / dividend-quotient shift register
  logic [31:0]       rem;

  logic [31:0] abs_a;
  logic [31:0] abs_b;
  logic [35:0] partial;
  logic [35:0] mul_upper;
  logic [32:0] div_shift;
  logic [33:0] div_diff;
  logic        div_ge;
  logic [64:0] mul_mag;
  logic [64:0] mul_full;
  logic [40:0] mul_shr;
  logic signed [31:0] mul_res;
  logic [55:0] quo;
  logic signed [31:0] div_res;

  always_comb begin
    abs_a     = a[31] ? (~a + 32'd1) : a;
    abs_b     = b[31] ? (~b + 32'd1) : b;

    // one radix-16 digit of the multiplier per cycle
    partial   = 36'(mag) * 36'(acc[3:0]);
    mul_upper = {4'b0, acc[63:32]} + partial;

    // one restoring division step per cycle
    div_shift = {rem, acc[55]};
    div_diff  = {1'b0, div_shift} - {2'b0, mag};
    div_ge    = !div_diff[33];

    // product: apply sign, floor shift by the fraction width, saturate
    mul_mag  = {1'b0, acc};
    mul_full = neg ? (~mul_mag + 65'd1) : mul_mag;
    mul_shr  = mul_full[64:24];
    if (!mul_shr[40] && (|mul_shr[39:31])) begin
      mul_res = srls_pkg::SAT_MAX;
    end else if (mul_shr[40] && !(&mul_shr[39:31])) begin
      mul_res = srls_pkg::SAT_MIN;
    end else begin
      mul_res = mul_shr[31:0];
    end

    // quotient: truncated toward zero, saturate
    quo = acc[55:0];
    if (neg) begin
      if ((|quo[55:32]) || (quo[31] && (|quo[30:0]))) begin
        div_res = srls_pkg::SAT_MIN;
      end else begin
        div_res = ~quo[31:0] + 32'd1;
      end
    end else begin
      if (|quo[55:31]) begin
        div_res = srls_pkg::SAT_MAX;
      end else begin
        div_res = quo[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
      cnt   <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (req.start) begin
            op  <= req.op;
            neg <= a[31] ^ b[31];
            cnt <= '0;
            if (req.op == srls_pkg::ALU_MUL) begin
              mag   <= abs_a;
              acc   <= {32'b0, abs_b};
              state <= ST_MUL;
            end else if (b == 32'sd0) begin
              // zero denominator: saturate by the sign of the numerator, or give zero for a zero numerator
              if (a == 32'sd0) begin
                result <= 32'sd0;
              end else begin
                result <= a[31] ? srls_pkg::SAT_MIN : srls_pkg::SAT_MAX;
              end
              done <= 1'b1;
            end else begin
              mag   <= abs_b;
              acc   <= {8'b0, abs_a, 24'b0};
              rem   <= '0;
              state <= ST_DIV;
            end
          end
        end
        ST_MUL: begin
          acc <= {mul_upper, acc[31:4]};
          cnt <= cnt + 6'd1;
          if (cnt == MUL_LAST) begin
            state <= ST_FIN;
          end
        end
        ST_DIV: begin
          rem <= div_ge ? div_diff[31:0] : div_shift[31:0];
          acc <= {8'b0, acc[54:0], div_ge};
          cnt <= cnt + 6'd1;
          if (cnt == DIV_LAST) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          result <= (op == srls_pkg::ALU_MUL) ? mul_res : div_res;
          done   <= 1'b1;
          state  <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- design/scalar_rls_estimator_unit.sv -----
// The estimate held before a sample is registered on acceptance and appears on the output
// in the next cycle. A new sample waits until the previous update has finished: seven
// products and one gain division, all on one serial unit.
// Reset (synchronous, active high) loads the register defaults and copies the initial
// estimate and covariance into the running state; no clearing pass is needed.
`timescale 1ns / 1ps

module scalar_rls_estimator_unit (
  input  logic               clk,
  input  logic               rst,
  // sample request
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] regressor,
  input  logic signed [31:0] measured_voltage,
  // result request
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] estimate,
  // configuration writes
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  // Sequencer steps, one per arithmetic operation
  localparam logic [2:0] STEP_PH   = 3'd0;  // ph   = P*h
  localparam logic [2:0] STEP_HPH  = 3'd1;  // den  = 1 + ph*h
  localparam logic [2:0] STEP_GAIN = 3'd2;  // K    = ph/den
  localparam logic [2:0] STEP_KH   = 3'd3;  // kh   = K*h
  localparam logic [2:0] STEP_COV  = 3'd4;  // P    = P - kh*P
  localparam logic [2:0] STEP_HS   = 3'd5;  // hs   = h*scale
  localparam logic [2:0] STEP_ERR  = 3'd6;  // err  = u - hs*theta
  localparam logic [2:0] STEP_EST  = 3'd7;  // theta = theta + K*err

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT
  } state_t;

  state_t state;
  logic [2:0] step;

  // configuration registers
  logic [24:0]        pred_scale;

  // running state
  logic signed [31:0] theta;
  logic signed [31:0] cov;

  // captured sample and intermediates
  logic signed [31:0] h;
  logic signed [31:0] u;
  logic signed [31:0] ph;
  logic signed [31:0] den;
  logic signed [31:0] gain;
  logic signed [31:0] prod;
  logic signed [31:0] err;

  // arithmetic unit request and operands
  srls_pkg::alu_req_t alu_req;
  logic signed [31:0] alu_a;
  logic signed [31:0] alu_b;
  logic               alu_done;
  logic signed [31:0] alu_result;

  logic signed [31:0] opnd_a;
  logic signed [31:0] opnd_b;

  // Hold off samples while busy, while a register write is pending (so it lands first),
  // and while the output register still holds a result.
  assign in_stall  = (state != ST_IDLE) || cfg_valid || out_valid;
  assign cfg_ready = (state == ST_IDLE);

  // Operand selection for the current step
  always_comb begin
    case (step)
      STEP_PH:   begin opnd_a = cov;  opnd_b = h;     end
      STEP_HPH:  begin opnd_a = ph;   opnd_b = h;     end
      STEP_GAIN: begin opnd_a = ph;   opnd_b = den;   end
      STEP_KH:   begin opnd_a = gain; opnd_b = h;     end
      STEP_COV:  begin opnd_a = prod; opnd_b = cov;   end
      STEP_HS:   begin opnd_a = h;    opnd_b = {7'b0, pred_scale}; end
      STEP_ERR:  begin opnd_a = prod; opnd_b = theta; end
      STEP_EST:  begin opnd_a = gain; opnd_b = err;   end
      default:   begin opnd_a = gain; opnd_b = err;   end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      step          <= STEP_PH;
      out_valid     <= 1'b0;
      alu_req.start <= 1'b0;
      alu_req.op    <= srls_pkg::ALU_MUL;
      pred_scale    <= srls_pkg::RESET_SCALE;
      theta         <= srls_pkg::RESET_EST;
      cov           <= {1'b0, srls_pkg::RESET_COV};
    end else begin
      alu_req.start <= 1'b0;

      // drop the result once the consumer takes it
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          // a write to an initial value loads the running state at once
          if (cfg_valid) begin
            case (cfg_index)
              srls_pkg::CFG_INIT_EST: begin
                theta <= cfg_data;
              end
              srls_pkg::CFG_INIT_COV: begin
                cov <= {1'b0, cfg_data[30:0]};
              end
              srls_pkg::CFG_PRED_SCALE: begin
                pred_scale <= cfg_data[24:0];
              end
              default: begin
              end
            endcase
          end
          // accept a sample: present the estimate held before it, then start the update
          if (in_valid && !in_stall) begin
            h         <= regressor;
            u         <= measured_voltage;
            estimate  <= theta;
            out_valid <= 1'b1;
            step      <= STEP_PH;
            state     <= ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          alu_req.start <= 1'b1;
          if (step == STEP_GAIN) begin
            alu_req.op <= srls_pkg::ALU_DIV;
          end else begin
            alu_req.op <= srls_pkg::ALU_MUL;
          end
          alu_a         <= opnd_a;
          alu_b         <= opnd_b;
          state         <= ST_WAIT;
        end
        ST_WAIT: begin
          if (alu_done) begin
            case (step)
              STEP_PH:   ph   <= alu_result;
              STEP_HPH:  den  <= srls_pkg::sat_s33({srls_pkg::Q_ONE[31], srls_pkg::Q_ONE}
                                                   + {alu_result[31], alu_result});
              STEP_GAIN: gain <= alu_result;
              STEP_KH:   prod <= alu_result;
              STEP_COV:  cov  <= srls_pkg::sat_s33({cov[31], cov}
                                                   - {alu_result[31], alu_result});
              STEP_HS:   prod <= alu_result;
              STEP_ERR:  err  <= srls_pkg::sat_s33({u[31], u}
                                                   - {alu_result[31], alu_result});
              STEP_EST:  theta <= srls_pkg::sat_s33({theta[31], theta}
                                                    + {alu_result[31], alu_result});
              default: begin
              end
            endcase
            // advance to the next operation, or go idle after the estimate update
            if (step == STEP_EST) begin
              state <= ST_IDLE;
            end else begin
              step  <= step + 3'd1;
              state <= ST_ISSUE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  srls_serial_alu u_alu (
    .clk    (clk),
    .rst    (rst),
    .req    (alu_req),
    .a      (alu_a),
    .b      (alu_b),
    .done   (alu_done),
    .result (alu_result)
  );

endmodule

// ----- sim/tb_scalar_rls_estimator_unit.sv -----
// Self-checking testbench for the scalar RLS estimator: scoreboard class and top module.
`timescale 1ns / 1ps

// Mirror of the estimator state; holds the estimates still owed by the block.
class rls_scoreboard;
  logic signed [31:0] init_est;
  logic signed [31:0] init_cov;
  logic signed [31:0] scale;
  logic signed [31:0] theta;
  logic signed [31:0] cov;
  logic signed [31:0] estimate_q[$];
  int errors;

  function new();
    errors = 0;
    init_est = srls_pkg::RESET_EST;
    init_cov = {1'b0, srls_pkg::RESET_COV};
    scale = {7'b0, srls_pkg::RESET_SCALE};
    theta = init_est;
    cov = init_cov;
  endfunction

  static function logic signed [31:0] clip32(longint v);
    if (v > longint'(srls_pkg::SAT_MAX)) return srls_pkg::SAT_MAX;
    if (v < longint'(srls_pkg::SAT_MIN)) return srls_pkg::SAT_MIN;
    return v[31:0];
  endfunction

  // Q8.24 product, floor rounding
  static function logic signed [31:0] fx_mul(logic signed [31:0] a, logic signed [31:0] b);
    longint p;
    p = longint'(a) * longint'(b);
    return clip32(p >>> srls_pkg::FRAC_BITS);
  endfunction

  static function logic signed [31:0] fx_add(logic signed [31:0] a, logic signed [31:0] b);
    return clip32(longint'(a) + longint'(b));
  endfunction

  static function logic signed [31:0] fx_sub(logic signed [31:0] a, logic signed [31:0] b);
    return clip32(longint'(a) - longint'(b));
  endfunction

  // Q8.24 quotient, truncated toward zero; a zero divisor saturates by sign, or gives zero
  static function logic signed [31:0] fx_div(logic signed [31:0] num, logic signed [31:0] den);
    if (den == 0) begin
      if (num > 0) return srls_pkg::SAT_MAX;
      if (num < 0) return srls_pkg::SAT_MIN;
      return '0;
    end
    return clip32((longint'(num) <<< srls_pkg::FRAC_BITS) / longint'(den));
  endfunction

  function void apply_write(srls_pkg::cfg_reg_t idx, logic [31:0] data);
    case (idx)
      srls_pkg::CFG_INIT_EST: begin
        init_est = data;
        theta = init_est;
      end
      srls_pkg::CFG_INIT_COV: begin
        init_cov = {1'b0, data[30:0]};
        cov = init_cov;
      end
      srls_pkg::CFG_PRED_SCALE: begin
        scale = {7'b0, data[24:0]};
      end
      default: begin
      end
    endcase
  endfunction

  function void note_sample(logic signed [31:0] h, logic signed [31:0] u);
    logic signed [31:0] ph, hph, den, gain, pred, err;
    estimate_q.push_back(theta);
    ph = fx_mul(cov, h);
    hph = fx_mul(ph, h);
    den = fx_add(srls_pkg::Q_ONE, hph);
    gain = fx_div(ph, den);
    pred = fx_mul(fx_mul(h, scale), theta);
    err = fx_sub(u, pred);
    cov = fx_sub(cov, fx_mul(fx_mul(gain, h), cov));
    theta = fx_add(theta, fx_mul(gain, err));
  endfunction

  function void check_estimate(logic signed [31:0] actual);
    logic signed [31:0] want;
    if (estimate_q.size() == 0) begin
      $display("%0t: estimate with none pending, expected none, actual %0d", $time, actual);
      errors++;
      return;
    end
    want = estimate_q.pop_front();
    if (actual !== want) begin
      $display("%0t: estimate mismatch, expected %0d, actual %0d", $time, want, actual);
      errors++;
    end
  endfunction

  function int pending();
    return estimate_q.size();
  endfunction
endclass

module tb_scalar_rls_estimator_unit;

  // Settle well past the time the block needs to finish the update of an accepted sample
  localparam int SETTLE_CYCLES = 400;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int RAND_PHASES   = 6;
  localparam int PHASE_ITEMS   = 225;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [31:0] regressor = '0;
  logic signed [31:0] measured_voltage = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] estimate;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;

  rls_scoreboard sb;

  // Idle percentages of the sample sender and the result receiver
  int send_idle_pct = 19;
  int recv_idle_pct = 84;
  int cycle_count = 0;

  // Plant gain that the well-formed samples follow within one phase
  int plant_gain = 0;

  scalar_rls_estimator_unit u_top (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .regressor        (regressor),
    .measured_voltage (measured_voltage),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .estimate         (estimate),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Stall the result request at random, once per cycle
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // Check every accepted result request against the oldest pending estimate
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.check_estimate(estimate);
    end
  end

  // Guard against a hang: end the run as failed past the cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Drive one sample request and hold it until accepted. Valid stays high on return,
  // so a back-to-back request just replaces the payload; an idle gap drops it first.
  task automatic send_sample(input logic signed [31:0] h, input logic signed [31:0] u);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    regressor <= h;
    measured_voltage <= u;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    sb.note_sample(h, u);
  endtask

  // Hold the sender off until every pending estimate has been taken
  task automatic hold_until_empty();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) begin
      @(posedge clk);
    end
  endtask

  // Wait for an idle block: nothing pending and the last update finished
  task automatic drain();
    hold_until_empty();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Issue one register write request; valid stays high for a following write
  task automatic write_reg(input srls_pkg::cfg_reg_t idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    sb.apply_write(idx, data);
  endtask

  // Program all three registers, optionally poke the unused index, then drop valid
  task automatic program_regs(input logic [31:0] est, input logic [31:0] cov,
                              input logic [31:0] scale, input bit poke_spare);
    if (poke_spare) begin
      write_reg(srls_pkg::CFG_SPARE, $urandom);
    end
    write_reg(srls_pkg::CFG_PRED_SCALE, scale);
    write_reg(srls_pkg::CFG_INIT_EST, est);
    write_reg(srls_pkg::CFG_INIT_COV, cov);
    cfg_valid <= 1'b0;
  endtask

  // Draw a random register setting; extremes come up often
  task automatic pick_config(output logic [31:0] est, output logic [31:0] cov,
                             output logic [31:0] scale);
    case ($urandom_range(0, 3))
      0: est = srls_pkg::SAT_MIN;
      1: est = srls_pkg::SAT_MAX;
      2: est = $urandom;
      default: est = int'($urandom_range(0, 1 << 25)) - (1 << 24);
    endcase
    case ($urandom_range(0, 3))
      0: cov = 32'h7fff_ffff;
      1: cov = $urandom;
      2: cov = '0;
      default: cov = $urandom_range(0, 1 << 24);
    endcase
    case ($urandom_range(0, 3))
      0: scale = '0;
      1: scale = srls_pkg::Q_ONE;
      2: scale = $urandom;
      default: scale = {7'b0, srls_pkg::RESET_SCALE};
    endcase
  endtask

  // Mostly samples of a linear plant with noise; the rest is raw noise and edge values
  task automatic pick_sample(output logic signed [31:0] h, output logic signed [31:0] u);
    int kind;
    longint y;
    kind = $urandom_range(0, 99);
    if (kind < 70) begin
      h = int'($urandom_range(0, 1 << 26)) - (1 << 25);
      y = (longint'(plant_gain) * longint'(h)) >>> srls_pkg::FRAC_BITS;
      u = int'(y) + int'($urandom_range(0, 1 << 17)) - (1 << 16);
    end else if (kind < 90) begin
      h = $urandom;
      u = $urandom;
    end else begin
      case ($urandom_range(0, 6))
        0: h = '0;
        1: h = srls_pkg::SAT_MAX;
        2: h = srls_pkg::SAT_MIN;
        3: h = srls_pkg::Q_ONE;
        4: h = -srls_pkg::Q_ONE;
        5: h = 32'sd1;
        default: h = -32'sd1;
      endcase
      u = $urandom;
    end
  endtask

  initial begin
    logic [31:0] est, cov, scale;
    logic signed [31:0] h, u;

    sb = new();

    // Hold reset; the block loads its register defaults
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: field extremes at the reset defaults
    send_sample('0, '0);
    send_sample(srls_pkg::SAT_MAX, srls_pkg::SAT_MAX);
    send_sample(srls_pkg::SAT_MIN, srls_pkg::SAT_MIN);
    send_sample(srls_pkg::SAT_MIN, srls_pkg::SAT_MAX);
    send_sample(srls_pkg::SAT_MAX, srls_pkg::SAT_MIN);
    send_sample(srls_pkg::Q_ONE, srls_pkg::Q_ONE);
    send_sample(-srls_pkg::Q_ONE, '0);
    send_sample(32'sd1, -32'sd1);
    drain();

    // Most negative estimate, largest covariance, zero scale
    program_regs(srls_pkg::SAT_MIN, 32'h7fff_ffff, '0, 1'b0);
    send_sample(srls_pkg::Q_ONE, srls_pkg::SAT_MAX);
    send_sample(-srls_pkg::Q_ONE, srls_pkg::SAT_MIN);
    drain();

    // Largest estimate, zero covariance, unity scale; poke the unused index too
    program_regs(srls_pkg::SAT_MAX, '0, srls_pkg::Q_ONE, 1'b1);
    send_sample(srls_pkg::Q_ONE, '0);
    send_sample(srls_pkg::Q_ONE, '0);
    drain();

    // Zero denominator with a negative gain numerator: a saturating update drives the
    // covariance to about -64, then h = 1/8 makes 1 + h*P*h exactly zero. Scale data
    // carries junk upper bits, leaving a scale just under two.
    program_regs(32'h0000_0000, 32'h4000_0000, 32'hffff_ffff, 1'b0);
    send_sample(32'sh1000_0000, srls_pkg::Q_ONE);
    send_sample(32'sh0020_0000, srls_pkg::Q_ONE);
    drain();

    // Same again with h = -1/8 for a positive numerator; covariance data has bit 31 set
    program_regs(32'h0100_0000, 32'hc000_0000, {7'b0, srls_pkg::RESET_SCALE}, 1'b0);
    send_sample(32'sh1000_0000, -srls_pkg::Q_ONE);
    send_sample(-32'sh0020_0000, -srls_pkg::Q_ONE);
    drain();

    // Random phases: sender idles lightly first, then receiver lightly, then no idling
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph / 2)
        0: begin
          send_idle_pct = 19;
          recv_idle_pct = 84;
        end
        1: begin
          send_idle_pct = 84;
          recv_idle_pct = 19;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      pick_config(est, cov, scale);
      program_regs(est, cov, scale, ($urandom_range(0, 1) == 1));
      plant_gain = int'($urandom_range(0, 1 << 24)) - (1 << 23);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick_sample(h, u);
        send_sample(h, u);
        // Pause mid-phase until the block has returned everything
        if (n == PHASE_ITEMS / 2) begin
          hold_until_empty();
        end
      end
      drain();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
